[hdl/lbcd_pkg.sv]
// Shared types and constants for the LRU block cache directory.
`timescale 1ns / 1ps

package lbcd_pkg;

    localparam int MaxEntries = 64;
    localparam int SlotW      = $clog2(MaxEntries);
    localparam int CountW     = SlotW + 1;
    localparam int DiskW      = 4;
    localparam int BlockW     = 8;
    localparam int TimeW      = 32;
    localparam int CounterW   = 32;
    localparam int ActionW    = 2;
    localparam int StatusW    = 2;
    localparam int CfgDataW   = 7;
    localparam int InDataW    = 16;
    localparam int OutDataW   = 72;

    localparam logic [ActionW-1:0] ActLookup = 2'd0;
    localparam logic [ActionW-1:0] ActUpdate = 2'd1;
    localparam logic [ActionW-1:0] ActInsert = 2'd2;

    localparam logic [StatusW-1:0] StatusHit = 2'd0;
    localparam logic [StatusW-1:0] StatusMiss = 2'd1;
    localparam logic [StatusW-1:0] StatusOff = 2'd2;

    localparam logic RegEnable  = 1'b0;
    localparam logic RegEntries = 1'b1;

    localparam logic [CountW-1:0] MinEntries = CountW'(2);
    localparam logic [CountW-1:0] MaxCount   = CountW'(MaxEntries);

    typedef struct packed {
        logic [DiskW-1:0]  disk;
        logic [BlockW-1:0] block;
        logic [TimeW-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic             match_found;
        logic [SlotW-1:0] match_idx;
        logic             empty_found;
        logic [SlotW-1:0] empty_idx;
        logic [SlotW-1:0] victim_idx;
    } scan_result_t;

endpackage

[hdl/lbcd_entry_ram.sv]
// Tag and time store for the directory slots, one write and one registered read port.
`timescale 1ns / 1ps

module lbcd_entry_ram
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [lbcd_pkg::SlotW-1:0] waddr,
    input  lbcd_pkg::entry_t           wdata,
    input  logic [lbcd_pkg::SlotW-1:0] raddr,
    output lbcd_pkg::entry_t           rdata
);
    import lbcd_pkg::*;

    entry_t mem [MaxEntries];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/lbcd_scan.sv]
// Shared compare unit that walks the slots one per cycle for match, empty and LRU victim.
`timescale 1ns / 1ps

module lbcd_scan
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        step,
    input  logic                        entry_valid,
    input  lbcd_pkg::entry_t            entry,
    input  logic [lbcd_pkg::SlotW-1:0]  entry_idx,
    input  logic [lbcd_pkg::DiskW-1:0]  req_disk,
    input  logic [lbcd_pkg::BlockW-1:0] req_block,
    output lbcd_pkg::scan_result_t      result
);
    import lbcd_pkg::*;

    logic             match_found_reg;
    logic [SlotW-1:0] match_idx_reg;
    logic             empty_found_reg;
    logic [SlotW-1:0] empty_idx_reg;
    logic             seen_reg;
    logic [SlotW-1:0] victim_idx_reg;
    logic [TimeW-1:0] oldest_reg;
    logic             is_match;
    logic             is_older;

    assign is_match = entry_valid && (entry.disk == req_disk) && (entry.block == req_block);
    // Strict compare keeps the lowest slot on ties.
    assign is_older = !seen_reg || (entry.stamp < oldest_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            seen_reg        <= 1'b0;
        end
        else if (clear)
        begin
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            seen_reg        <= 1'b0;
        end
        else if (step)
        begin
            seen_reg <= 1'b1;
            if (is_match && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
            end
            if (!entry_valid && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (is_match && !match_found_reg)
            begin
                match_idx_reg <= entry_idx;
            end
            if (!entry_valid && !empty_found_reg)
            begin
                empty_idx_reg <= entry_idx;
            end
            if (is_older)
            begin
                oldest_reg     <= entry.stamp;
                victim_idx_reg <= entry_idx;
            end
        end
    end

    assign result.match_found = match_found_reg;
    assign result.match_idx   = match_idx_reg;
    assign result.empty_found = empty_found_reg;
    assign result.empty_idx   = empty_idx_reg;
    assign result.victim_idx  = victim_idx_reg;

endmodule

[hdl/lru_block_cache_directory_top.sv]
// Top level of the LRU block cache directory: sequencer, counters, valid marks and ports.
`timescale 1ns / 1ps

// A request is taken only while the sequencer is idle and then walks the active slots
// through a single read port of the tag store, one slot per cycle, feeding one shared
// compare unit. A lookup, update or insert on an enabled cache scans entries_in_use
// (clamped to 2..64) slots, then goes through ST_DRAIN and ST_DECIDE; a request on a
// disabled cache or with an unused action code goes straight to ST_DECIDE. The result
// sits in an output register, and the next request is accepted once the sequencer is idle.
// Writing enable from 0 to 1 clears all valid marks and the access clock at once.
module lru_block_cache_directory_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action [1:0], disk [5:2], block [13:6], zero [15:14]
    input  logic [lbcd_pkg::InDataW-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], slot [7:2], query_count [39:8], hit_count [71:40]
    output logic [lbcd_pkg::OutDataW-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [lbcd_pkg::CfgDataW-1:0] cfg_data
);
    import lbcd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    state_t               state_reg, state_next;
    logic [ActionW-1:0]   act_reg;
    logic [DiskW-1:0]     disk_reg;
    logic [BlockW-1:0]    block_reg;
    logic                 skip_reg;
    logic [CountW-1:0]    n_reg;
    logic [SlotW-1:0]     idx_reg;
    logic [SlotW-1:0]     rd_idx_reg;
    logic                 rd_pend_reg;
    logic                 enable_reg;
    logic [CountW-1:0]    entries_reg;
    logic [TimeW-1:0]     clock_reg;
    logic [CounterW-1:0]  queries_reg;
    logic [CounterW-1:0]  hits_reg;
    logic [CounterW-1:0]  hits_next;
    logic [MaxEntries-1:0] valid_reg;
    logic                 m_tvalid_reg;
    logic [OutDataW-1:0]  m_tdata_reg;

    logic [ActionW-1:0]   in_action;
    logic [DiskW-1:0]     in_disk;
    logic [BlockW-1:0]    in_block;
    logic                 accept;
    logic                 out_free;
    logic                 finish;
    logic                 last_issue;
    logic [CountW-1:0]    n_clamped;
    logic                 in_skip;

    scan_result_t         scan_res;
    entry_t               rd_entry;
    entry_t               wr_entry;
    logic                 ram_we;
    logic [SlotW-1:0]     target;
    logic                 do_write;
    logic                 is_hit;
    logic [StatusW-1:0]   status;
    logic [SlotW-1:0]     slot;

    assign in_action = s_tdata[1:0];
    assign in_disk   = s_tdata[5:2];
    assign in_block  = s_tdata[13:6];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign finish    = (state_reg == ST_DECIDE) && out_free;
    assign last_issue = ({1'b0, idx_reg} == (n_reg - CountW'(1)));

    assign in_skip = !enable_reg || (in_action != ActLookup && in_action != ActUpdate
                                     && in_action != ActInsert);

    always_comb
    begin
        n_clamped = entries_reg;
        if (entries_reg < MinEntries)
        begin
            n_clamped = MinEntries;
        end
        else if (entries_reg > MaxCount)
        begin
            n_clamped = MaxCount;
        end
    end

    // Decision once the walk is complete.
    always_comb
    begin
        status   = StatusMiss;
        slot     = '0;
        do_write = 1'b0;
        is_hit   = 1'b0;
        target   = scan_res.match_idx;
        if (!enable_reg)
        begin
            status = StatusOff;
        end
        else if (!skip_reg)
        begin
            case (act_reg)
                ActLookup:
                begin
                    if (scan_res.match_found)
                    begin
                        status   = StatusHit;
                        slot     = scan_res.match_idx;
                        do_write = 1'b1;
                        is_hit   = 1'b1;
                    end
                end
                ActUpdate:
                begin
                    if (scan_res.match_found)
                    begin
                        status   = StatusHit;
                        slot     = scan_res.match_idx;
                        do_write = 1'b1;
                    end
                end
                ActInsert:
                begin
                    if (!scan_res.match_found)
                    begin
                        target   = scan_res.empty_found ? scan_res.empty_idx
                                                        : scan_res.victim_idx;
                        status   = StatusHit;
                        slot     = target;
                        do_write = 1'b1;
                    end
                end
                default:
                begin
                    status = StatusMiss;
                end
            endcase
        end
    end

    assign hits_next = is_hit ? hits_reg + CounterW'(1) : hits_reg;

    // A matching update rewrites the same tags, so every write carries the full entry.
    assign wr_entry.disk  = disk_reg;
    assign wr_entry.block = block_reg;
    assign wr_entry.stamp = clock_reg;
    assign ram_we         = finish && do_write;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_skip ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_pend_reg  <= 1'b0;
            enable_reg   <= 1'b0;
            entries_reg  <= MaxCount;
            clock_reg    <= '0;
            queries_reg  <= '0;
            hits_reg     <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    RegEnable:
                    begin
                        if (cfg_data[0] && !enable_reg)
                        begin
                            valid_reg <= '0;
                            clock_reg <= '0;
                        end
                        enable_reg <= cfg_data[0];
                    end
                    RegEntries:
                    begin
                        entries_reg <= cfg_data;
                    end
                    default:
                    begin
                        enable_reg <= enable_reg;
                    end
                endcase
            end

            if (accept)
            begin
                idx_reg <= '0;
                if (!in_skip)
                begin
                    clock_reg <= clock_reg + TimeW'(1);
                    if (in_action == ActLookup)
                    begin
                        queries_reg <= queries_reg + CounterW'(1);
                    end
                end
            end
            else if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + SlotW'(1);
            end

            if (ram_we)
            begin
                valid_reg[target] <= 1'b1;
            end

            if (finish)
            begin
                hits_reg     <= hits_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (accept)
        begin
            act_reg   <= in_action;
            disk_reg  <= in_disk;
            block_reg <= in_block;
            skip_reg  <= in_skip;
            n_reg     <= n_clamped;
        end
        if (finish)
        begin
            m_tdata_reg <= {hits_next, queries_reg, slot, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    lbcd_entry_ram u_entry_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (target),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    lbcd_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .step        (rd_pend_reg),
        .entry_valid (valid_reg[rd_idx_reg]),
        .entry       (rd_entry),
        .entry_idx   (rd_idx_reg),
        .req_disk    (disk_reg),
        .req_block   (block_reg),
        .result      (scan_res)
    );

endmodule

[dv/lbcd_directory_checker.sv]
// Checker for the LRU block cache directory: tracks the directory state and checks each result.
`timescale 1ns / 1ps

module lbcd_directory_checker
    import lbcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  errors,
    output int                  results_seen
);

    typedef struct packed {
        logic [StatusW-1:0]  status;
        logic [SlotW-1:0]    slot;
        logic [CounterW-1:0] query_count;
        logic [CounterW-1:0] hit_count;
    } reply_t;

    logic                line_valid [MaxEntries];
    logic [DiskW-1:0]    line_disk  [MaxEntries];
    logic [BlockW-1:0]   line_block [MaxEntries];
    logic [TimeW-1:0]    line_stamp [MaxEntries];
    logic [TimeW-1:0]    access_clock;
    logic [CounterW-1:0] lookups;
    logic [CounterW-1:0] lookup_hits;
    logic                cache_on;
    logic [CfgDataW-1:0] entries_reg;
    reply_t              pending_replies [$];

    // Applies one request to the tracked directory and returns the reply it must produce.
    function automatic reply_t apply_request(logic [ActionW-1:0] act, logic [DiskW-1:0] d,
                                             logic [BlockW-1:0] b);
        reply_t r;
        int     span;
        int     hit_at;
        int     target;
        int     i;
        r.status = StatusMiss;
        r.slot   = '0;
        span = int'(entries_reg);
        if (span < int'(MinEntries))
            span = int'(MinEntries);
        if (span > MaxEntries)
            span = MaxEntries;
        hit_at = -1;
        for (i = 0; i < span; i++)
            if (hit_at < 0 && line_valid[i] && line_disk[i] == d && line_block[i] == b)
                hit_at = i;
        if (!cache_on)
            r.status = StatusOff;
        else if (act == ActLookup || act == ActUpdate)
        begin
            if (act == ActLookup)
                lookups++;
            access_clock++;
            if (hit_at >= 0)
            begin
                line_stamp[hit_at] = access_clock;
                if (act == ActLookup)
                    lookup_hits++;
                r.status = StatusHit;
                r.slot   = SlotW'(hit_at);
            end
        end
        else if (act == ActInsert)
        begin
            access_clock++;
            if (hit_at < 0)
            begin
                target = -1;
                for (i = 0; i < span; i++)
                    if (target < 0 && !line_valid[i])
                        target = i;
                // No free slot: evict the oldest stamp, the lowest slot winning a tie.
                if (target < 0)
                begin
                    target = 0;
                    for (i = 1; i < span; i++)
                        if (line_stamp[i] < line_stamp[target])
                            target = i;
                end
                line_valid[target] = 1'b1;
                line_disk[target]  = d;
                line_block[target] = b;
                line_stamp[target] = access_clock;
                r.status = StatusHit;
                r.slot   = SlotW'(target);
            end
        end
        r.query_count = lookups;
        r.hit_count   = lookup_hits;
        return r;
    endfunction

    function automatic int field_mismatch(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int     bad;
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MaxEntries; i++)
            begin
                line_valid[i] = 1'b0;
                line_disk[i]  = '0;
                line_block[i] = '0;
                line_stamp[i] = '0;
            end
            access_clock = '0;
            lookups      = '0;
            lookup_hits  = '0;
            cache_on     = 1'b0;
            entries_reg  = CfgDataW'(MaxEntries);
            pending_replies.delete();
            errors       <= 0;
            results_seen <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == RegEnable)
                begin
                    // Turning the cache on drops every entry and restarts the clock.
                    if (cfg_data[0] && !cache_on)
                    begin
                        for (int i = 0; i < MaxEntries; i++)
                            line_valid[i] = 1'b0;
                        access_clock = '0;
                    end
                    cache_on = cfg_data[0];
                end
                else
                    entries_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(apply_request(s_tdata[1:0], s_tdata[5:2],
                                                        s_tdata[13:6]));
            if (m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result 0x%0h arrived with no request outstanding", m_tdata);
                    bad++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    bad += field_mismatch("status", 32'(want.status), 32'(m_tdata[1:0]));
                    bad += field_mismatch("slot", 32'(want.slot), 32'(m_tdata[7:2]));
                    bad += field_mismatch("query_count", want.query_count, m_tdata[39:8]);
                    bad += field_mismatch("hit_count", want.hit_count, m_tdata[71:40]);
                end
                results_seen <= results_seen + 1;
            end
            errors <= errors + bad;
        end
    end

endmodule

[dv/lru_block_cache_directory_top_test.sv]
// Testbench top for the LRU block cache directory: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module lru_block_cache_directory_top_test;

    import lbcd_pkg::*;

    localparam logic [ActionW-1:0] ActReserved = 2'd3;
    localparam int CycleLimit = 1_000_000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = RegEnable;
    logic [CfgDataW-1:0] cfg_data  = '0;

    int errors;
    int results_seen;
    int requests_sent = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    always #1 clk = ~clk;

    lru_block_cache_directory_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lbcd_directory_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .results_seen (results_seen)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("lru_block_cache_directory_top_test: done, errors");
            $finish;
        end
    end

    // The valid stays high after acceptance so that back-to-back requests need no gap.
    task automatic send_request(input logic [ActionW-1:0] act, input logic [DiskW-1:0] d,
                                input logic [BlockW-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, d, act};
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_seen != requests_sent)
            @(posedge clk);
    endtask

    // With hold set the valid stays up because another register write follows at once.
    task automatic write_reg(input logic idx, input logic [CfgDataW-1:0] value, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [11:0]         tag_pool [48];
        logic [11:0]         tag;
        logic [ActionW-1:0]  act;
        logic [CfgDataW-1:0] span_cfg;
        int                  live;
        int                  pool_size;
        int                  roll;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part; the cache starts out disabled.
        send_request(ActLookup, 4'd15, 8'd255);
        wait_drained();
        write_reg(RegEntries, 7'd0, 1'b1);
        write_reg(RegEnable, 7'h7F, 1'b0);
        send_request(ActInsert, 4'd0, 8'd0);
        send_request(ActInsert, 4'd15, 8'd255);
        send_request(ActInsert, 4'd0, 8'd0);
        send_request(ActLookup, 4'd0, 8'd0);
        send_request(ActInsert, 4'd5, 8'hA5);
        send_request(ActLookup, 4'd15, 8'd255);
        send_request(ActUpdate, 4'd0, 8'd0);
        send_request(ActUpdate, 4'd7, 8'd7);
        send_request(ActReserved, 4'd10, 8'h5A);
        wait_drained();
        write_reg(RegEntries, 7'd127, 1'b0);
        send_request(ActInsert, 4'd15, 8'd255);
        send_request(ActInsert, 4'd8, 8'h80);
        wait_drained();
        write_reg(RegEntries, 7'd3, 1'b0);
        send_request(ActLookup, 4'd8, 8'h80);
        send_request(ActInsert, 4'd9, 8'h81);
        wait_drained();
        // Slots above the active range keep their tags while hidden.
        write_reg(RegEntries, 7'd1, 1'b0);
        send_request(ActLookup, 4'd15, 8'd255);
        wait_drained();
        write_reg(RegEntries, 7'd64, 1'b1);
        write_reg(RegEnable, 7'h55, 1'b0);
        send_request(ActLookup, 4'd8, 8'h80);
        wait_drained();
        write_reg(RegEnable, 7'h2A, 1'b0);
        send_request(ActInsert, 4'd1, 8'd1);
        wait_drained();
        write_reg(RegEnable, 7'h01, 1'b0);
        send_request(ActLookup, 4'd0, 8'd0);

        // Random part: two segments per pacing phase, each with its own size and tag pool.
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg / 2)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 70; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 70; end
                default: begin idle_pct = 32; stall_pct <= 32; end
            endcase
            case (seg)
                0: span_cfg = 7'd2;
                1: span_cfg = 7'd4;
                2: span_cfg = 7'd64;
                4: span_cfg = 7'd3;
                5: span_cfg = 7'd8;
                7: span_cfg = 7'd1;
                default: span_cfg = CfgDataW'($urandom_range(0, 127));
            endcase
            live = int'(span_cfg);
            if (live < int'(MinEntries))
                live = int'(MinEntries);
            if (live > MaxEntries)
                live = MaxEntries;
            pool_size = (live + 3 > 48) ? 48 : live + 3;
            for (int i = 0; i < pool_size; i++)
                tag_pool[i] = 12'($urandom());

            wait_drained();
            // Every third segment starts from an emptied directory.
            if (seg % 3 == 1)
                write_reg(RegEnable, {6'($urandom()), 1'b0}, 1'b1);
            write_reg(RegEntries, span_cfg, 1'b1);
            write_reg(RegEnable, {6'($urandom()), 1'b1}, 1'b0);

            for (int k = 0; k < 80; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    act = ActLookup;
                else if (roll < 60)
                    act = ActUpdate;
                else if (roll < 95)
                    act = ActInsert;
                else
                    act = ActReserved;
                if ($urandom_range(0, 99) < 85)
                    tag = tag_pool[$urandom_range(0, pool_size - 1)];
                else
                    tag = 12'($urandom());
                send_request(act, tag[11:8], tag[7:0]);
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("lru_block_cache_directory_top_test: done, clean");
        else
            $display("lru_block_cache_directory_top_test: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hdl/lbcd_pkg.sv
hdl/lbcd_entry_ram.sv
hdl/lbcd_scan.sv
hdl/lru_block_cache_directory_top.sv
dv/lbcd_directory_checker.sv
dv/lru_block_cache_directory_top_test.sv
